[rtl/cole_pkg.sv]
// shared types and constants for the circular ordered list engine
package cole_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SlotWidth  = $clog2(Capacity);
  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  typedef logic [SlotWidth-1:0]  slot_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [ValueWidth-1:0] value_t;

  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdInsert = 2'd1,
    CmdRemove = 2'd2,
    CmdCount  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StDone = 2'd0,
    StNone = 2'd1,
    StFull = 2'd2
  } status_e;

  // node record held in one memory word
  typedef struct packed {
    value_t value;
    slot_t  next;
    slot_t  prev;
  } node_t;

endpackage

[rtl/cole_free_map.sv]
// free slot bitmap with lowest free slot lookup
module cole_free_map (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             release_i,
  input  cole_pkg::slot_t  release_slot_i,
  output cole_pkg::slot_t  free_slot_o
);

  logic [cole_pkg::Capacity-1:0] free_q;
  cole_pkg::slot_t               lowest_q;
  cole_pkg::slot_t               lowest_d;

  // priority search registered; map only changes once per item
  always_comb begin
    lowest_d = '0;
    for (int i = cole_pkg::Capacity - 1; i >= 0; i--) begin
      if (free_q[i]) lowest_d = cole_pkg::SlotWidth'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q   <= '1;
      lowest_q <= '0;
    end else begin
      if (take_i) free_q[lowest_q] <= 1'b0;
      if (release_i) free_q[release_slot_i] <= 1'b1;
      lowest_q <= lowest_d;
    end
  end

  assign free_slot_o = lowest_q;

endmodule

[rtl/circular_ordered_list_engine_top.sv]
// top level of the circular ordered list engine
//
//  channel | valid     | ready     | payload
//  in      | in_valid_i| in_ready_o| command_i, item_value_i, target_value_i
//  out     | out_valid_o| out_ready_i| status_o, node_count_o
//
// count and refusals go straight to the result word; append reads the head record
// and links ahead of it; insert and remove walk the list one node record read per
// cycle until a match or a full lap, then link in the new node or unlink the match.
// the walk is set by the single read port of the node memory.
// reset clears the free map, head and count; node memory needs no clearing.
// a finished word waits in the output register; the next item is taken once
// it is gone or while it is being taken.
module circular_ordered_list_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [31:0] target_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [6:0]  node_count_o
);

  typedef enum logic [3:0] {
    SIdle, SPrep, SWalk, SLink1, SLink2, SLink3, SFix, SDone
  } state_e;

  state_e                  state_q;
  cole_pkg::cmd_e          cmd_q;
  cole_pkg::value_t        item_q, target_q;
  cole_pkg::slot_t         head_q, cur_q, at_q, new_q;
  cole_pkg::count_t        size_q, walked_q;
  cole_pkg::node_t         at_node_q;
  logic [1:0]              status_q;
  logic                    out_valid_q;

  // node memory, one read and one write port
  cole_pkg::node_t mem_q [cole_pkg::Capacity];
  cole_pkg::node_t rd_data_q;
  cole_pkg::slot_t rd_addr;
  logic            wr_en;
  cole_pkg::slot_t wr_addr;
  cole_pkg::node_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  // free map
  logic            take, rel;
  cole_pkg::slot_t free_slot;

  cole_free_map u_free (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .release_i      (rel),
    .release_slot_i (at_q),
    .free_slot_o    (free_slot)
  );

  logic in_fire;
  cole_pkg::value_t key;
  logic full, empty;

  assign in_ready_o  = (state_q == SIdle) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign node_count_o = size_q;
  assign full  = (size_q == cole_pkg::CountWidth'(cole_pkg::Capacity));
  assign empty = (size_q == '0);
  assign key   = (cmd_q == cole_pkg::CmdInsert) ? target_q : item_q;

  // read address chosen by the walk and the linking steps
  always_comb begin
    rd_addr = cur_q;
    if (state_q == SPrep) rd_addr = head_q;
    if (state_q == SWalk) rd_addr = rd_data_q.next;
    // predecessor record, used in the forward link step
    if (state_q == SLink1) rd_addr = at_node_q.prev;
    // successor record, used in the backward link step
    if (state_q == SLink2) begin
      rd_addr = (cmd_q == cole_pkg::CmdRemove) ? at_node_q.next : at_q;
    end
  end

  // memory writes per linking step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = new_q;
    wr_data = at_node_q;
    take    = 1'b0;
    rel     = 1'b0;
    case (state_q)
      SLink1: begin
        // new node record; remove releases the matched slot instead
        wr_en = (cmd_q != cole_pkg::CmdRemove);
        take  = wr_en;
        wr_addr = free_slot;
        if (cmd_q == cole_pkg::CmdAppend && empty) begin
          wr_data = '{value: item_q, next: free_slot, prev: free_slot};
        end else begin
          wr_data = '{value: item_q, next: at_q, prev: at_node_q.prev};
        end
        rel = (cmd_q == cole_pkg::CmdRemove);
      end
      SLink2: begin
        // forward link of the predecessor; memory read gives its record
        wr_en   = !(cmd_q == cole_pkg::CmdAppend && empty)
                  && !(cmd_q == cole_pkg::CmdRemove && size_q == 1);
        wr_addr = at_node_q.prev;
        wr_data = rd_data_q;
        wr_data.next = (cmd_q == cole_pkg::CmdRemove) ? at_node_q.next : new_q;
      end
      SLink3: begin
        // backward link of the successor
        wr_en   = !(cmd_q == cole_pkg::CmdAppend && empty)
                  && !(cmd_q == cole_pkg::CmdRemove && size_q == 1);
        wr_addr = (cmd_q == cole_pkg::CmdRemove) ? at_node_q.next : at_q;
        wr_data = rd_data_q;
        wr_data.prev = (cmd_q == cole_pkg::CmdRemove) ? at_node_q.prev : new_q;
        // the predecessor may be the successor: a remove from two nodes, or an add to one
        if (wr_addr == at_node_q.prev) begin
          wr_data.next = (cmd_q == cole_pkg::CmdRemove) ? at_node_q.next : new_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      size_q      <= '0;
      status_q    <= cole_pkg::StDone;
      cmd_q       <= cole_pkg::CmdCount;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (in_fire) begin
            cmd_q    <= cole_pkg::cmd_e'(command_i);
            item_q   <= cole_pkg::ValueWidth'(item_value_i);
            target_q <= cole_pkg::ValueWidth'(target_value_i);
            status_q <= cole_pkg::StDone;
            state_q  <= SPrep;
          end
        end
        SPrep: begin
          walked_q <= '0;
          cur_q    <= head_q;
          at_q     <= head_q;
          case (cmd_q)
            cole_pkg::CmdAppend: begin
              if (full) begin
                status_q <= cole_pkg::StFull;
                state_q  <= SDone;
              end else begin
                state_q <= SFix;  // read head record
              end
            end
            cole_pkg::CmdInsert: begin
              if (empty) begin
                status_q <= cole_pkg::StNone;
                state_q  <= SDone;
              end else if (full) begin
                status_q <= cole_pkg::StFull;
                state_q  <= SDone;
              end else begin
                state_q <= SWalk;
              end
            end
            cole_pkg::CmdRemove: begin
              if (empty) begin
                status_q <= cole_pkg::StNone;
                state_q  <= SDone;
              end else begin
                state_q <= SWalk;
              end
            end
            default: state_q <= SDone;
          endcase
        end
        SFix: begin
          // append: head record now in rd_data; link ahead of head
          at_q      <= head_q;
          at_node_q <= rd_data_q;
          state_q   <= SLink1;
        end
        SWalk: begin
          // rd_data holds the record at cur_q
          if (rd_data_q.value == key) begin
            at_node_q <= rd_data_q;
            at_q      <= cur_q;
            state_q   <= SLink1;
          end else if (walked_q + 1'b1 == size_q) begin
            status_q <= cole_pkg::StNone;
            state_q  <= SDone;
          end else begin
            walked_q <= walked_q + 1'b1;
            cur_q    <= rd_data_q.next;
          end
        end
        SLink1: begin
          new_q   <= free_slot;
          state_q <= SLink2;
        end
        SLink2: begin
          state_q <= SLink3;
        end
        SLink3: begin
          case (cmd_q)
            cole_pkg::CmdAppend: begin
              if (empty) head_q <= new_q;
              size_q <= size_q + 1'b1;
            end
            cole_pkg::CmdInsert: begin
              if (at_q == head_q) head_q <= new_q;
              size_q <= size_q + 1'b1;
            end
            default: begin
              if (size_q != 1 && at_q == head_q) head_q <= at_node_q.next;
              size_q <= size_q - 1'b1;
            end
          endcase
          state_q <= SDone;
        end
        SDone: begin
          out_valid_q <= 1'b1;
          state_q     <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

[rtl/cole_checker.sv]
// port level checks for the circular ordered list engine, bound to the top
module cole_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [6:0] node_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(node_count_o))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> node_count_o <= 7'(cole_pkg::Capacity))
    else $error("node count beyond pool size");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= cole_pkg::StFull)
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken before result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == cole_pkg::StFull
      |-> node_count_o == 7'(cole_pkg::Capacity))
    else $error("full status with room left");

endmodule

bind circular_ordered_list_engine_top cole_checker u_cole_checker (.*);
